// ===== rtl/evfifo_pkg.sv =====
package evfifo_pkg;

   // Field widths fixed by the interface
   localparam int EVENT_W    = 64;
   localparam int COUNT_W    = 4;
   localparam int DROP_W     = 64;
   localparam int SLOTS_W    = 4;

   // Usable slot count after reset
   localparam logic [SLOTS_W-1:0] SLOTS_RESET = 4'd15;

   // Request opcodes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEND
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;        // request accepted this cycle
      logic load_read;   // capture memory read data into the response
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_pop;     // pending request is a pop
   } dp_stat_type;

endpackage

// ===== rtl/evfifo_ctrl.sv =====
module evfifo_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  evfifo_pkg::dp_stat_type  stat,
   output evfifo_pkg::ctrl_cmd_type cmd
);

   evfifo_pkg::state_type state_ff;
   evfifo_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= evfifo_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         evfifo_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_pop ? evfifo_pkg::ST_FETCH : evfifo_pkg::ST_SEND;
            end
         end
         evfifo_pkg::ST_FETCH: begin
            state_in = evfifo_pkg::ST_SEND;
         end
         evfifo_pkg::ST_SEND: begin
            if (!rsp_stall) begin
               state_in = evfifo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = evfifo_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      cmd.take      = 1'b0;
      cmd.load_read = 1'b0;
      case (state_ff)
         evfifo_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         evfifo_pkg::ST_FETCH: begin
            cmd.load_read = 1'b1;
         end
         evfifo_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/evfifo_dp.sv =====
module evfifo_dp #(
   parameter int SLOT_COUNT = 16,
   parameter int EVENT_BITS = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  evfifo_pkg::ctrl_cmd_type                cmd,
   output evfifo_pkg::dp_stat_type                 stat,
   input  logic                                    csr_write_enable,
   input  logic [evfifo_pkg::SLOTS_W-1:0]          csr_write_data,
   input  logic                                    req_cmd,
   input  logic [evfifo_pkg::EVENT_W-1:0]          req_event_word,
   output logic                                    rsp_accepted,
   output logic [evfifo_pkg::EVENT_W-1:0]          rsp_read_event,
   output logic [evfifo_pkg::COUNT_W-1:0]          rsp_occupancy,
   output logic [evfifo_pkg::DROP_W-1:0]           rsp_dropped_total
);

   // Wrap point never exceeds usable_slots + 1, so only that many entries are used
   localparam int MAX_WRAP = (1 << evfifo_pkg::SLOTS_W);
   localparam int DEPTH    = (SLOT_COUNT < MAX_WRAP) ? SLOT_COUNT : MAX_WRAP;
   localparam int PW       = $clog2(DEPTH);
   localparam int WW       = evfifo_pkg::SLOTS_W + 1;

   logic [evfifo_pkg::SLOTS_W-1:0] slots_ff;
   logic [PW-1:0]                  wp_ff, wp_in;
   logic [PW-1:0]                  rp_ff, rp_in;
   logic [evfifo_pkg::DROP_W-1:0]  drop_ff, drop_in;
   logic                           acc_ff, acc_in;
   logic [evfifo_pkg::COUNT_W-1:0] occ_ff, occ_in;
   logic [evfifo_pkg::EVENT_W-1:0] rdata_ff;
   logic [EVENT_BITS-1:0]          mem [DEPTH];
   logic [EVENT_BITS-1:0]          mem_q_ff;

   logic [WW-1:0] wrap_raw, wrap;
   logic [PW-1:0] wp_cur, rp_cur, wp_nxt, rp_nxt;
   logic [WW-1:0] wp_inc, rp_inc;
   logic [WW-1:0] held;
   logic          mem_we;

   assign stat.req_pop = (req_cmd == evfifo_pkg::CMD_POP);

   // Wrap point, limited to the store depth
   assign wrap_raw = {1'b0, slots_ff} + WW'(1);
   assign wrap     = (wrap_raw > WW'(DEPTH)) ? WW'(DEPTH) : wrap_raw;

   // Positions at or past the wrap point restart the queue
   always_comb begin
      if ((WW'(wp_ff) >= wrap) || (WW'(rp_ff) >= wrap)) begin
         wp_cur = '0;
         rp_cur = '0;
      end else begin
         wp_cur = wp_ff;
         rp_cur = rp_ff;
      end
   end

   // Advanced positions
   assign wp_inc = WW'(wp_cur) + WW'(1);
   assign rp_inc = WW'(rp_cur) + WW'(1);
   assign wp_nxt = (wp_inc >= wrap) ? '0 : wp_inc[PW-1:0];
   assign rp_nxt = (rp_inc >= wrap) ? '0 : rp_inc[PW-1:0];

   // Push / pop decision
   always_comb begin
      wp_in   = wp_cur;
      rp_in   = rp_cur;
      drop_in = drop_ff;
      acc_in  = 1'b0;
      mem_we  = 1'b0;
      if (req_cmd == evfifo_pkg::CMD_PUSH) begin
         if (wp_nxt == rp_cur) begin
            drop_in = drop_ff + evfifo_pkg::DROP_W'(1);
         end else begin
            mem_we = cmd.take;
            wp_in  = wp_nxt;
            acc_in = 1'b1;
         end
      end else begin
         if (wp_cur != rp_cur) begin
            rp_in  = rp_nxt;
            acc_in = 1'b1;
         end
      end
   end

   // Occupancy after the request
   always_comb begin
      if (wp_in >= rp_in) begin
         held = WW'(wp_in) - WW'(rp_in);
      end else begin
         held = wrap - WW'(rp_in) + WW'(wp_in);
      end
      occ_in = held[evfifo_pkg::COUNT_W-1:0];
   end

   // Queue control state; a register write empties the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= evfifo_pkg::SLOTS_RESET;
         wp_ff    <= '0;
         rp_ff    <= '0;
         drop_ff  <= '0;
      end else if (csr_write_enable) begin
         slots_ff <= csr_write_data;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else if (cmd.take) begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         drop_ff <= drop_in;
      end
   end

   // Event store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_cur] <= req_event_word[EVENT_BITS-1:0];
      end
      if (cmd.take) begin
         mem_q_ff <= mem[rp_cur];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         acc_ff   <= acc_in;
         occ_ff   <= occ_in;
         rdata_ff <= '0;
      end else if (cmd.load_read) begin
         rdata_ff <= acc_ff ? evfifo_pkg::EVENT_W'(mem_q_ff) : '0;
      end
   end

   assign rsp_accepted      = acc_ff;
   assign rsp_read_event    = rdata_ff;
   assign rsp_occupancy     = occ_ff;
   assign rsp_dropped_total = drop_ff;

endmodule

// ===== rtl/event_fifo_with_drop_count_core.sv =====
// Circular event queue with a counter of refused pushes. Each request is a
// push (req_cmd 0) or a pop (req_cmd 1) and yields exactly one response with
// an accepted flag, the popped word (zero unless a pop succeeded), the
// occupancy after the request and the 64-bit wrapping drop total. A push
// into a full queue or a pop from an empty queue is refused. csr_write_data
// sets how many events the queue may hold (0 to 15, reset 15); writing it
// empties the queue but keeps the drop total; it must be written only while
// no request is in flight, which the block itself does not enforce. One
// request is handled at a time: a push gives its response the cycle after
// acceptance; a pop passes through ST_FETCH before ST_SEND, because the
// event store has a single registered read port. Once the response is taken
// the block is ready again the next cycle.
module event_fifo_with_drop_count_core #(
   parameter int SLOT_COUNT = 16,
   parameter int EVENT_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [evfifo_pkg::SLOTS_W-1:0]      csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [evfifo_pkg::EVENT_W-1:0]      req_event_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [evfifo_pkg::EVENT_W-1:0]      rsp_read_event,
   output logic [evfifo_pkg::COUNT_W-1:0]      rsp_occupancy,
   output logic [evfifo_pkg::DROP_W-1:0]       rsp_dropped_total
);

   evfifo_pkg::ctrl_cmd_type ctrl_cmd;
   evfifo_pkg::dp_stat_type  dp_stat;

   // Sequencer
   evfifo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   // Queue datapath
   evfifo_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .EVENT_BITS (EVENT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctrl_cmd),
      .stat              (dp_stat),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_cmd           (req_cmd),
      .req_event_word    (req_event_word),
      .rsp_accepted      (rsp_accepted),
      .rsp_read_event    (rsp_read_event),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_dropped_total (rsp_dropped_total)
   );

`ifndef SYNTHESIS
   // Only one request in flight: no acceptance while a response is shown
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   // A refused request never returns data
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_read_event == '0))
      else $error("refused request returned a nonzero word");

   // Pop read data is captured right before the response is shown
   a_fetch_then_send: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_read |=> rsp_valid)
      else $error("pop read capture not followed by a response");
`endif

endmodule
